// ----- sv/signed_int_to_decimal_ascii_core_macros.svh -----
// Assertion macros for the RTL file that checks itself.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define SIDA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define SIDA_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ----- sv/sida_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sida_pkg;

	localparam int unsigned RADIX_DEFAULT = 10;
	localparam int unsigned MAX_CHARS     = 11;
	localparam logic [6:0]  CHAR_ZERO     = 7'd48;
	localparam logic [6:0]  CHAR_MINUS    = 7'd45;

	// Clamp a requested radix to 2..10.
	function automatic int unsigned clamp_radix(input int unsigned radix);
		int unsigned r;
		r = radix;
		if (r < 2) r = 2;
		if (r > 10) r = 10;
		return r;
	endfunction

	// Digits needed for the largest 32-bit magnitude in this base.
	function automatic int unsigned num_digits(input int unsigned base);
		longint unsigned p;
		int unsigned n;
		p = 1;
		n = 1;
		for (int i = 0; i < 32; i++) begin
			if (p * base <= 64'hFFFF_FFFF) begin
				p = p * base;
				n = n + 1;
			end
		end
		return n;
	endfunction

	// base**k, evaluated at elaboration only.
	function automatic logic [31:0] radix_weight(input int unsigned base, input int unsigned k);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < 32; i++) begin
			if (i < k) p = p * base;
		end
		return p[31:0];
	endfunction

endpackage

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii_core.sv -----
// Signed 32-bit integer to ASCII text converter.
//
// Input stream (s_*): one 32-bit two's complement word per value. The core
// accepts a word only while it is idle; a value occupies it until its last
// character has been loaded into the output register.
// Output stream (m_*): one character per word, most significant digit
// first, no leading zeros, '-' first for negative values, tlast on the
// final character. Zero gives the single character '0'.
// Digits come from one shared compare/subtract unit that walks the table of
// radix weights from the top, resolving one digit bit per cycle; each digit
// then passes through an emit step. A '-' is loaded in a sign step between
// the accept and the first digit. Leading zero positions are walked too, so
// the first digit of a short value waits until every higher weight has been
// tried. Text is capped at 11 characters.
// The output register frees the sequencer: if the receiver stalls, the
// sequencer holds in its sign or emit step until the register drains.
// Reset (arst_n low) drops any conversion in flight and empties the
// output register; the core comes back idle and ready.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core
	import sida_pkg::*;
#(
	parameter int unsigned RADIX = RADIX_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [6:0] char_code, [7] zero pad
	output logic             m_tlast    // last
);

	localparam int unsigned BASE  = clamp_radix(RADIX);
	localparam int unsigned NDIG  = num_digits(BASE);
	localparam int unsigned DBITS = $clog2(BASE);
	localparam int unsigned KW    = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int unsigned BW    = (DBITS > 1) ? $clog2(DBITS) : 1;
	localparam int unsigned CW    = $clog2(MAX_CHARS + 1);
	localparam int unsigned XW    = 32 + DBITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIGN,
		ST_STEP,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [31:0]       rem_q;
	logic [KW-1:0]     k_q;
	logic [BW-1:0]     b_q;
	logic [DBITS-1:0]  digit_q;
	logic [CW-1:0]     cnt_q;
	logic              started_q;
	logic              out_valid_q;
	logic [6:0]        char_q;
	logic              last_q;

	// Weight table, one constant per digit position.
	logic [31:0] weight_tbl [NDIG];
	for (genvar g = 0; g < NDIG; g++) begin : g_weight
		assign weight_tbl[g] = radix_weight(BASE, g);
	end

	// Shared compare/subtract unit: remainder against weight << bit.
	logic [XW-1:0] rem_ext;
	logic [XW-1:0] wsh;
	logic [XW-1:0] diff;
	logic          ge;
	logic [31:0]   mag;
	logic          out_free;
	logic          emit_last;
	logic          skip_zero;
	logic          load_out;

	assign rem_ext   = {{DBITS{1'b0}}, rem_q};
	assign wsh       = {{DBITS{1'b0}}, weight_tbl[k_q]} << b_q;
	assign diff      = rem_ext - wsh;
	assign ge        = (rem_ext >= wsh);
	assign mag       = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;
	assign out_free  = !out_valid_q || m_tready;
	assign emit_last = (k_q == '0) || (cnt_q == CW'(MAX_CHARS - 1));
	assign skip_zero = (digit_q == '0) && !started_q && (k_q != '0);
	assign load_out  = out_free &&
		((state_q == ST_SIGN) || ((state_q == ST_EMIT) && !skip_zero));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			b_q         <= '0;
			digit_q     <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			rem_q       <= '0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			// Load a new word, or drain the output register when the receiver takes it.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						rem_q     <= mag;
						k_q       <= KW'(NDIG - 1);
						b_q       <= BW'(DBITS - 1);
						digit_q   <= '0;
						cnt_q     <= '0;
						started_q <= 1'b0;
						state_q   <= s_tdata[31] ? ST_SIGN : ST_STEP;
					end
				end
				ST_SIGN: begin
					// Load the minus sign once the output register is free.
					if (out_free) begin
						char_q      <= CHAR_MINUS;
						last_q      <= 1'b0;
						cnt_q       <= cnt_q + CW'(1);
						state_q     <= ST_STEP;
					end
				end
				ST_STEP: begin
					// Resolve one digit bit per cycle.
					if (ge) begin
						rem_q   <= diff[31:0];
						digit_q <= digit_q | (DBITS'(1) << b_q);
					end
					if (b_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						b_q <= b_q - BW'(1);
					end
				end
				ST_EMIT: begin
					if (skip_zero) begin
						// Drop a leading zero and advance to the next weight.
						k_q     <= k_q - KW'(1);
						b_q     <= BW'(DBITS - 1);
						digit_q <= '0;
						state_q <= ST_STEP;
					end else if (out_free) begin
						char_q      <= CHAR_ZERO + 7'(digit_q);
						last_q      <= emit_last;
						cnt_q       <= cnt_q + CW'(1);
						started_q   <= 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q - KW'(1);
							b_q     <= BW'(DBITS - 1);
							digit_q <= '0;
							state_q <= ST_STEP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SIDA_ASSERT(a_cnt_bound, cnt_q <= CW'(MAX_CHARS), "character count beyond limit")
	`SIDA_ASSERT_IMP(a_digit_range, state_q == ST_EMIT, 32'(digit_q) < BASE, "digit not below radix")
	`SIDA_ASSERT_IMP(a_minus_not_last, m_tvalid && m_tdata[6:0] == CHAR_MINUS, !m_tlast, "minus sign flagged last")
	`SIDA_ASSERT_IMP(a_char_legal, m_tvalid, m_tdata[6:0] == CHAR_MINUS || (m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] < CHAR_ZERO + 7'(BASE)), "illegal character")

endmodule

`default_nettype wire

// ----- sim/tb_signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps

// Testbench for signed_int_to_decimal_ascii_core.
// Values go in on the s_* stream, text comes back one character per word on
// the m_* stream. Every accepted value is turned into its expected text:
// either typed in the directed table or worked out by text_of_value below.
// The characters are then queued and compared in order against the output.

module tb_signed_int_to_decimal_ascii_core;
	import sida_pkg::*;

	// Use the base the core is built with, held to the legal range.
	localparam int unsigned BASE = (RADIX_DEFAULT < 2) ? 2 :
		((RADIX_DEFAULT > 10) ? 10 : RADIX_DEFAULT);
	localparam int DIRECTED_ROWS = 22;
	// Settle time at the end, allowing well over the time the core spends on a value.
	localparam int SETTLE_CYCLES = 120;
	localparam int REPORT_LIMIT  = 10;

	// One output character as it should appear on m_tdata / m_tlast.
	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} char_t;

	// The whole text of one value, first character in code[0].
	typedef struct packed {
		logic [3:0]                    count;
		logic [MAX_CHARS-1:0][6:0]     code;
	} text_t;

	typedef struct {
		logic [31:0] value;
		string       text;   // empty: work the text out instead
	} row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	char_t pending_chars [$];
	int    tx_idle_pct = 0;
	int    rx_idle_pct = 0;
	int    mismatch_count = 0;
	int    values_sent = 0;
	int    negatives_sent = 0;
	int    zeros_sent = 0;
	int    full_texts = 0;
	int    chars_seen = 0;

	// Typed-in text where it is plain from the value; the rest is predicted.
	row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'hFFFF_FFFF,  "-1"},
		'{32'h7FFF_FFFF,  "2147483647"},
		'{32'h8000_0000,  "-2147483648"},
		'{32'd9,          ""},
		'{32'd10,         ""},
		'{-32'd9,         ""},
		'{-32'd10,        ""},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'd999999999,  ""},
		'{32'd1000000000, ""},
		'{-32'd999999999, ""},
		'{-32'd1000000000, ""},
		'{32'h7FFF_FFFE,  ""},
		'{32'h8000_0001,  ""},
		'{32'd1999999999, ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd123456789,  ""},
		'{-32'd987654321, ""}
	};

	signed_int_to_decimal_ascii_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [31:0] value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [6:0] char_code, [7] zero pad
		.m_tlast  (m_tlast)     // last
	);

	always #1 clk = ~clk;

	// Predict the text: sign first, then the magnitude digit by digit,
	// most significant first, cut to the character limit.
	function automatic text_t text_of_value(input logic [31:0] value);
		text_t      t;
		logic [31:0] mag;
		logic [3:0] digit [0:31];
		logic [6:0] full [0:33];
		int         ndig;
		int         len;
		int         i;
		t = '0;
		ndig = 0;
		len = 0;
		// Form the magnitude unsigned so the most negative value survives.
		mag = value[31] ? (32'd0 - value) : value;
		if (value[31]) begin
			full[len] = CHAR_MINUS;
			len++;
		end
		do begin
			digit[ndig] = 4'(mag % BASE);
			mag = mag / BASE;
			ndig++;
		end while (mag != 0);
		for (i = ndig - 1; i >= 0; i--) begin
			full[len] = CHAR_ZERO + 7'(digit[i]);
			len++;
		end
		if (len > MAX_CHARS)
			len = MAX_CHARS;
		t.count = 4'(len);
		for (i = 0; i < len; i++)
			t.code[i] = full[i];
		return t;
	endfunction

	function automatic text_t text_of_string(input string s);
		text_t t;
		byte   b;
		int    i;
		t = '0;
		t.count = 4'(s.len());
		for (i = 0; i < s.len(); i++) begin
			b = s[i];
			t.code[i] = b[6:0];
		end
		return t;
	endfunction

	// Spread values over signs, digit counts, decade edges and range ends.
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		logic [31:0] decade;
		decade = 32'd1;
		repeat ($urandom_range(9)) decade = decade * 10;
		case ($urandom_range(5))
			0, 1: begin
				v = $urandom;
			end
			2: begin
				v = $urandom_range(200) - 100;
			end
			3: begin
				// Just below, on, or just above a power of ten.
				v = decade + $urandom_range(2) - 1;
				if ($urandom_range(1))
					v = -v;
			end
			4: begin
				v = $urandom_range(1) ? (32'h7FFF_FFFF - $urandom_range(15)) :
					(32'h8000_0000 + $urandom_range(15));
			end
			default: begin
				v = $urandom % decade;
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Offer one value, idling first at the current rate; hold it until taken,
	// then queue its characters.
	task automatic send_value(input logic [31:0] value, input text_t text);
		int i;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		for (i = 0; i < text.count; i++)
			pending_chars.push_back('{code: text.code[i], last: (i == text.count - 1)});
		values_sent++;
		if (value[31])
			negatives_sent++;
		if (value == 32'd0)
			zeros_sent++;
		if (text.count == MAX_CHARS)
			full_texts++;
	endtask

	// Hold off the sender until every queued character has come back.
	task automatic drain_text();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	// Stall the receiver at random at the current rate.
	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Compare each output word against the oldest queued character.
	always @(posedge clk) begin : char_check
		char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unexpected char tdata=%02h tlast=%b",
						$realtime, m_tdata, m_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: char mismatch: expected tdata=%02h tlast=%b, got tdata=%02h tlast=%b",
							$realtime, {1'b0, want.code}, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	initial begin
		int tx_pct [3];
		int rx_pct [3];
		int random_count [3];
		int phase;
		int i;
		text_t t;
		logic [31:0] v;
		tx_pct = '{11, 71, 0};
		rx_pct = '{71, 11, 0};
		random_count = '{50, 50, 48};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (phase = 0; phase < 3; phase++) begin
			tx_idle_pct = tx_pct[phase];
			rx_idle_pct = rx_pct[phase];
			if (phase == 0) begin
				for (i = 0; i < DIRECTED_ROWS; i++) begin
					if (directed_rows[i].text.len() != 0)
						t = text_of_string(directed_rows[i].text);
					else
						t = text_of_value(directed_rows[i].value);
					send_value(directed_rows[i].value, t);
				end
			end
			for (i = 0; i < random_count[phase]; i++) begin
				v = random_value();
				t = text_of_value(v);
				send_value(v, t);
			end
			// Let the core empty out before the rates change.
			drain_text();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Converted %0d values (%0d negative, %0d zero, %0d at full width) into %0d chars",
			values_sent, negatives_sent, zeros_sent, full_texts, chars_seen);
		$display("Stall mixes: sender-light/receiver-heavy, swapped, and free running");
		if (mismatch_count == 0 && pending_chars.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- signed_int_to_decimal_ascii_core.f -----
+incdir+sv
sv/sida_pkg.sv
sv/signed_int_to_decimal_ascii_core.sv
sim/tb_signed_int_to_decimal_ascii_core.sv
